// File: rtl/drmpr_pkg.sv
package drmpr_pkg;

    localparam int HDR_FIRST_BIT = 7;   // 0x80
    localparam int HDR_LAST_BIT  = 6;   // 0x40
    localparam int HDR_PPI_BIT   = 3;   // 0x08
    localparam int CONT_W        = 3;   // continuity mask 7
    localparam int ID_W          = 2;   // id mask 3

    localparam int BODY_W  = 16;
    localparam int UNIT_W  = 24;
    localparam int INDEX_W = 17;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

    typedef enum logic [1:0] {
        REG_BODY_BYTES     = 2'd0,
        REG_PACKET_ID      = 2'd1,
        REG_MAX_UNIT_BYTES = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_LENGTH     = 4'd1,
        ST_CRC        = 4'd2,
        ST_ID         = 4'd3,
        ST_PPI        = 4'd4,
        ST_CONTINUITY = 4'd5,
        ST_COUNT      = 4'd6,
        ST_FILL       = 4'd7,
        ST_LIMIT      = 4'd8,
        ST_EMPTY      = 4'd9
    } status_t;

    typedef struct packed {
        logic [BODY_W-1:0] body_bytes;
        logic [ID_W-1:0]   packet_id;
        logic [UNIT_W-1:0] max_unit_bytes;
    } cfg_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       end_of_packet;
        logic       crc_ok;
    } item_t;

endpackage

// File: rtl/drmpr_if.sv
interface drmpr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       end_of_packet;
    logic       crc_ok;

    modport source (output valid, output packet_byte, output end_of_packet, output crc_ok,
                    input ready);
    modport sink   (input valid, input packet_byte, input end_of_packet, input crc_ok,
                    output ready);
endinterface

interface drmpr_out_if;
    logic        valid;
    logic        ready;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        packet_done;
    logic [3:0]  status;
    logic        starts_unit;
    logic        unit_done;
    logic [23:0] unit_length;

    modport source (output valid, output data_valid, output data_byte, output packet_done,
                    output status, output starts_unit, output unit_done,
                    output unit_length, input ready);
    modport sink   (input valid, input data_valid, input data_byte, input packet_done,
                    input status, input starts_unit, input unit_done,
                    input unit_length, output ready);
endinterface

// File: rtl/drmpr_cfg.sv
module drmpr_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [drmpr_pkg::APB_AW-1:0]  paddr,
    input  logic [drmpr_pkg::APB_DW-1:0]  pwdata,
    output logic [drmpr_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    output drmpr_pkg::cfg_t               cfg
);
    import drmpr_pkg::*;

    logic [BODY_W-1:0] body_bytes_reg;
    logic [ID_W-1:0]   packet_id_reg;
    logic [UNIT_W-1:0] max_unit_bytes_reg;
    logic              wr_en;
    reg_idx_t          sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = reg_idx_t'(paddr[APB_AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_bytes_reg     <= BODY_W'(1);
            packet_id_reg      <= '0;
            max_unit_bytes_reg <= '1;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_BODY_BYTES:     body_bytes_reg     <= pwdata[BODY_W-1:0];
                REG_PACKET_ID:      packet_id_reg      <= pwdata[ID_W-1:0];
                REG_MAX_UNIT_BYTES: max_unit_bytes_reg <= pwdata[UNIT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_BODY_BYTES:     prdata = APB_DW'(body_bytes_reg);
            REG_PACKET_ID:      prdata = APB_DW'(packet_id_reg);
            REG_MAX_UNIT_BYTES: prdata = APB_DW'(max_unit_bytes_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.body_bytes     = body_bytes_reg;
    assign cfg.packet_id      = packet_id_reg;
    assign cfg.max_unit_bytes = max_unit_bytes_reg;

endmodule

// File: rtl/drmpr_in_reg.sv
module drmpr_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    drmpr_in_if.sink         in_ch,
    output logic             item_valid,
    output drmpr_pkg::item_t item,
    input  logic             item_ready
);
    import drmpr_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign in_ch.ready = !valid_reg || item_ready;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (item_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // hold the transaction until the core has room for it
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.packet_byte   <= in_ch.packet_byte;
            item_reg.end_of_packet <= in_ch.end_of_packet;
            item_reg.crc_ok        <= in_ch.crc_ok;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/drmpr_core.sv
module drmpr_core (
    input  logic             clk,
    input  logic             rst_n,
    input  drmpr_pkg::cfg_t  cfg,
    input  logic             item_valid,
    input  drmpr_pkg::item_t item,
    output logic             item_ready,
    drmpr_out_if.source      out_ch
);
    import drmpr_pkg::*;

    // reassembly state
    logic               unit_active_reg;
    logic [CONT_W-1:0]  prev_cont_reg;
    logic [UNIT_W-1:0]  unit_count_reg;
    logic [INDEX_W-1:0] byte_index_reg;
    logic [7:0]         header_latch_reg;
    logic [7:0]         useful_count_reg;
    logic               fill_nonzero_reg;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               data_valid_reg;
    logic [7:0]         data_byte_reg;
    logic               packet_done_reg;
    status_t            status_reg;
    logic               starts_unit_reg;
    logic               unit_done_reg;
    logic [UNIT_W-1:0]  unit_length_reg;

    logic               fire;
    logic [7:0]         b;
    logic [INDEX_W-1:0] idx;
    logic [INDEX_W-1:0] body_ext;
    logic               idx_zero;
    logic               idx_one;
    logic [7:0]         hdr;
    logic               padded;
    logic [BODY_W-1:0]  useful;
    logic               dv;
    logic               fill_set;
    logic               fill_eff;
    logic               first;
    logic               last;
    logic [UNIT_W-1:0]  base;
    logic [UNIT_W:0]    sum;
    logic [CONT_W-1:0]  cont;
    logic [CONT_W-1:0]  cont_expect;
    status_t            status;

    assign item_ready = !out_valid_reg || out_ch.ready;
    assign fire       = item_valid && item_ready;

    assign b        = item.packet_byte;
    assign idx      = byte_index_reg;
    assign body_ext = INDEX_W'(cfg.body_bytes);
    assign idx_zero = (idx == '0);
    assign idx_one  = (idx == INDEX_W'(1));
    assign hdr      = idx_zero ? b : header_latch_reg;
    assign padded   = hdr[HDR_PPI_BIT];

    always_comb
    begin
        if (!padded)
            useful = cfg.body_bytes;
        else if (idx_one)
            useful = BODY_W'(b);
        else if (idx_zero)
            useful = '0;
        else
            useful = BODY_W'(useful_count_reg);
    end

    // useful region and fill tracking
    always_comb
    begin
        dv       = 1'b0;
        fill_set = 1'b0;
        if (!padded)
            dv = !idx_zero && (idx <= body_ext);
        else if (!idx_zero && !idx_one)
        begin
            if ((idx - INDEX_W'(2)) < INDEX_W'(useful_count_reg))
                dv = (idx <= body_ext);
            else
                fill_set = (b != 8'd0);
        end
    end

    assign fill_eff    = fill_nonzero_reg || fill_set;
    assign first       = hdr[HDR_FIRST_BIT];
    assign last        = hdr[HDR_LAST_BIT];
    assign cont        = hdr[CONT_W-1:0];
    assign cont_expect = prev_cont_reg + CONT_W'(1);
    assign base        = first ? '0 : unit_count_reg;
    assign sum         = {1'b0, base} + (UNIT_W+1)'(useful);

    // first matching error wins
    always_comb
    begin
        if (cfg.body_bytes == '0 || idx != body_ext)
            status = ST_LENGTH;
        else if (!item.crc_ok)
            status = ST_CRC;
        else if (hdr[5:4] != cfg.packet_id)
            status = ST_ID;
        else if (padded && !last)
            status = ST_PPI;
        else if (!first && (!unit_active_reg || cont != cont_expect))
            status = ST_CONTINUITY;
        else if (padded && useful >= cfg.body_bytes)
            status = ST_COUNT;
        else if (padded && fill_eff)
            status = ST_FILL;
        else if (sum > {1'b0, cfg.max_unit_bytes})
            status = ST_LIMIT;
        else if (last && sum == '0)
            status = ST_EMPTY;
        else
            status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_active_reg  <= 1'b0;
            prev_cont_reg    <= '0;
            unit_count_reg   <= '0;
            byte_index_reg   <= '0;
            header_latch_reg <= '0;
            useful_count_reg <= '0;
            fill_nonzero_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (idx_zero)
                header_latch_reg <= b;
            if (idx_one)
                useful_count_reg <= b;
            if (item.end_of_packet)
            begin
                byte_index_reg   <= '0;
                fill_nonzero_reg <= 1'b0;
                if (status != ST_OK)
                begin
                    // drop the unit
                    unit_active_reg <= 1'b0;
                    unit_count_reg  <= '0;
                    prev_cont_reg   <= '0;
                end
                else
                begin
                    prev_cont_reg   <= cont;
                    unit_active_reg <= !last;
                    unit_count_reg  <= last ? '0 : sum[UNIT_W-1:0];
                end
            end
            else
            begin
                fill_nonzero_reg <= fill_eff;
                if (byte_index_reg != INDEX_MAX)
                    byte_index_reg <= byte_index_reg + INDEX_W'(1);
            end
        end
    end

    always_comb
    begin
        if (fire)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_valid_reg  <= dv;
            data_byte_reg   <= dv ? b : 8'd0;
            packet_done_reg <= item.end_of_packet;
            status_reg      <= item.end_of_packet ? status : ST_OK;
            starts_unit_reg <= item.end_of_packet && status == ST_OK && first;
            unit_done_reg   <= item.end_of_packet && status == ST_OK && last;
            unit_length_reg <= (item.end_of_packet && status == ST_OK && last) ?
                               sum[UNIT_W-1:0] : '0;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.data_valid  = data_valid_reg;
    assign out_ch.data_byte   = data_byte_reg;
    assign out_ch.packet_done = packet_done_reg;
    assign out_ch.status      = status_reg;
    assign out_ch.starts_unit = starts_unit_reg;
    assign out_ch.unit_done   = unit_done_reg;
    assign out_ch.unit_length = unit_length_reg;

    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && unit_done_reg |-> packet_done_reg && status_reg == ST_OK)
        else $error("unit completed on a packet that was not ok");

    a_mid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !packet_done_reg |->
            status_reg == ST_OK && !starts_unit_reg && !unit_done_reg)
        else $error("packet status reported before packet end");

    a_index_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.end_of_packet |=> byte_index_reg == '0 && !fill_nonzero_reg)
        else $error("byte index not cleared at packet end");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && unit_done_reg |-> unit_length_reg != '0)
        else $error("empty unit reported as complete");

    a_err_drop: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.end_of_packet && status != ST_OK |=>
            !unit_active_reg && unit_count_reg == '0 && prev_cont_reg == '0)
        else $error("unit state kept after an error");

endmodule

// File: rtl/drm_packet_reassembler.sv
// Packet-mode reassembler for fixed-length data packets.
// in_ch carries one packet byte per transaction, header first, CRC already
// stripped; end_of_packet marks the last byte and crc_ok gives the outer CRC
// verdict with it. out_ch returns exactly one result per input transaction:
// the byte flagged as useful payload where it falls in the useful region,
// and on the last byte the packet status, unit start and unit completion
// with its length.
// The APB port sets body_bytes (0x0), packet_id (0x4) and max_unit_bytes
// (0x8); write it only while no transaction is in flight.
// Each result passes the input register, then the result register. Throughput
// is one byte per cycle unless out_ch stalls: all header decode, counting and
// status checks sit in one combinational step between the two registers.
// Reset clears the unit and continuity state and empties both registers.
// When the receiver stalls, the result is held and the input register, if empty,
// still takes one more transaction before in_ch.ready drops.
module drm_packet_reassembler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [drmpr_pkg::APB_AW-1:0]  paddr,
    input  logic [drmpr_pkg::APB_DW-1:0]  pwdata,
    output logic [drmpr_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    drmpr_in_if.sink                      in_ch,
    drmpr_out_if.source                   out_ch
);
    import drmpr_pkg::*;

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  item_ready;

    drmpr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    drmpr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    drmpr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .out_ch     (out_ch)
    );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import drmpr_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic        packet_done;
        status_t     status;
        logic        starts_unit;
        logic        unit_done;
        logic [23:0] unit_length;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    drmpr_in_if  in_ch ();
    drmpr_out_if out_ch ();

    drm_packet_reassembler dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // register copies
    logic [BODY_W-1:0] model_body;
    logic [ID_W-1:0]   model_id;
    logic [UNIT_W-1:0] model_max;

    // reassembly state
    logic               unit_active_q;
    logic [CONT_W-1:0]  prev_cont;
    logic [UNIT_W-1:0]  unit_bytes;
    logic [INDEX_W-1:0] index_q;
    logic [7:0]         hdr_q;
    logic [15:0]        useful_q;
    logic               fill_bad;

    outcome_t   expected_results [$];
    logic [7:0] pkt_bytes [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int mismatches     = 0;
    int bytes_sent     = 0;
    int packets_seen   = 0;
    int units_completed = 0;
    int settings_applied = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off while hold_left runs down
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic outcome_t predict_byte(input logic [7:0] b, input logic eop,
                                              input logic crc);
        outcome_t    r;
        logic [7:0]  hdr;
        logic        padded;
        logic        first;
        logic        last;
        int unsigned useful;
        int unsigned base;
        int unsigned body;
        int unsigned idx;
        status_t     st;
        r = '0;
        body = 32'(model_body);
        idx = 32'(index_q);
        hdr = (idx == 0) ? b : hdr_q;
        padded = hdr[HDR_PPI_BIT];
        if (!padded)
            useful = body;
        else if (idx == 1)
            useful = 32'(b);
        else if (idx >= 2)
            useful = 32'(useful_q);
        else
            useful = 0;
        if (idx == 0)
            hdr_q = b;
        if (idx == 1)
            useful_q = {8'h00, b};
        if (!padded)
            r.data_valid = (idx >= 1) && (idx <= body);
        else if (idx >= 2)
        begin
            if (idx - 2 < useful)
                r.data_valid = (idx <= body);
            else if (b != 8'h00)
                fill_bad = 1'b1;
        end
        if (r.data_valid)
            r.data_byte = b;
        if (eop)
        begin
            first = hdr[HDR_FIRST_BIT];
            last = hdr[HDR_LAST_BIT];
            base = first ? 0 : 32'(unit_bytes);
            st = ST_OK;
            if (body == 0 || idx != body)
                st = ST_LENGTH;
            else if (!crc)
                st = ST_CRC;
            else if (hdr[5:4] != model_id)
                st = ST_ID;
            else if (padded && !last)
                st = ST_PPI;
            else if (!first && (!unit_active_q || hdr[2:0] != 3'(prev_cont + 3'd1)))
                st = ST_CONTINUITY;
            else if (padded && useful > body - 1)
                st = ST_COUNT;
            else if (padded && fill_bad)
                st = ST_FILL;
            else if (useful > model_max || base > model_max - useful)
                st = ST_LIMIT;
            else if (last && base + useful == 0)
                st = ST_EMPTY;
            r.packet_done = 1'b1;
            r.status = st;
            if (st != ST_OK)
            begin
                // drop the unit and forget continuity
                unit_active_q = 1'b0;
                unit_bytes = '0;
                prev_cont = '0;
            end
            else
            begin
                prev_cont = hdr[2:0];
                r.starts_unit = first;
                unit_bytes = UNIT_W'(base + useful);
                unit_active_q = 1'b1;
                if (last)
                begin
                    r.unit_done = 1'b1;
                    r.unit_length = unit_bytes;
                    unit_bytes = '0;
                    unit_active_q = 1'b0;
                    units_completed++;
                end
            end
            index_q = '0;
            fill_bad = 1'b0;
            packets_seen++;
        end
        else if (index_q != INDEX_MAX)
            index_q = index_q + INDEX_W'(1);
        return r;
    endfunction

    always @(negedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.data_valid  = out_ch.data_valid;
            got.data_byte   = out_ch.data_byte;
            got.packet_done = out_ch.packet_done;
            got.status      = status_t'(out_ch.status);
            got.starts_unit = out_ch.starts_unit;
            got.unit_done   = out_ch.unit_done;
            got.unit_length = out_ch.unit_length;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at cycle %0d: dv=%0b byte=%02h done=%0b st=%0d",
                             cycle_count, got.data_valid, got.data_byte, got.packet_done,
                             got.status);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at cycle %0d", cycle_count);
                        $display("  expected dv=%0b byte=%02h done=%0b st=%0d start=%0b udone=%0b len=%0d",
                                 want.data_valid, want.data_byte, want.packet_done, want.status,
                                 want.starts_unit, want.unit_done, want.unit_length);
                        $display("  actual   dv=%0b byte=%02h done=%0b st=%0d start=%0b udone=%0b len=%0d",
                                 got.data_valid, got.data_byte, got.packet_done, got.status,
                                 got.starts_unit, got.unit_done, got.unit_length);
                    end
                end
            end
        end
    end

    task automatic send_packet_byte(input logic [7:0] b, input logic eop, input logic crc);
        outcome_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.packet_byte   <= b;
        in_ch.end_of_packet <= eop;
        in_ch.crc_ok        <= crc;
        do
            @(negedge clk);
        while (!in_ch.ready);
        @(posedge clk);
        r = predict_byte(b, eop, crc);
        expected_results = {expected_results, r};
        bytes_sent++;
    endtask

    task automatic wait_for_results;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t r, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_BODY_BYTES:     model_body = value[BODY_W-1:0];
            REG_PACKET_ID:      model_id   = value[ID_W-1:0];
            REG_MAX_UNIT_BYTES: model_max  = value[UNIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int body, input int id, input int max_unit);
        wait_for_results();
        apb_write(REG_BODY_BYTES, APB_DW'(body));
        apb_write(REG_PACKET_ID, APB_DW'(id));
        apb_write(REG_MAX_UNIT_BYTES, APB_DW'(max_unit));
        settings_applied++;
    endtask

    function automatic logic [7:0] header_byte(input logic first, input logic last,
                                               input logic [1:0] id, input logic padded,
                                               input logic [2:0] cont);
        return {first, last, id, padded, cont};
    endfunction

    task automatic build_packet(input logic first, input logic last, input logic padded,
                                input logic [1:0] id, input logic [2:0] cont,
                                input int body_len, input int useful, input bit dirty);
        pkt_bytes.delete();
        pkt_bytes = {pkt_bytes, header_byte(first, last, id, padded, cont)};
        for (int i = 1; i <= body_len; i++)
        begin
            if (!padded)
                pkt_bytes = {pkt_bytes, 8'($urandom)};
            else if (i == 1)
                pkt_bytes = {pkt_bytes, 8'(useful)};
            else if (i - 2 < useful)
                pkt_bytes = {pkt_bytes, 8'($urandom)};
            else
                pkt_bytes = {pkt_bytes, (dirty && i == body_len) ? 8'($urandom_range(1, 255))
                                                                  : 8'h00};
        end
    endtask

    task automatic send_built(input logic crc);
        int n;
        n = pkt_bytes.size();
        for (int i = 0; i < n; i++)
            send_packet_byte(pkt_bytes[i], i == n - 1,
                             (i == n - 1) ? crc : 1'($urandom_range(0, 1)));
    endtask

    // mostly well-formed units that follow the open unit's continuity
    task automatic send_random_packet;
        int          kind;
        int          blen;
        int          useful;
        int          cap;
        int          n;
        logic        first;
        logic        last;
        logic        padded;
        logic [1:0]  id;
        logic [2:0]  cont;
        bit          dirty;
        logic        crc;
        blen = 32'(model_body);
        cap = (blen - 1 > 255) ? 255 : blen - 1;
        first = !unit_active_q || ($urandom_range(0, 5) == 0);
        last = ($urandom_range(0, 2) == 0);
        padded = last && ($urandom_range(0, 1) == 1);
        id = model_id;
        cont = first ? 3'($urandom) : 3'(prev_cont + 3'd1);
        useful = (blen > 1) ? $urandom_range(0, cap) : 0;
        dirty = 1'b0;
        crc = 1'b1;
        kind = $urandom_range(0, 99);
        if (kind >= 90)
        begin
            // noise: loose bytes, perhaps leaving a partial packet behind
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_packet_byte(8'($urandom), (i == n - 1) && ($urandom_range(0, 1) == 1),
                                 1'($urandom_range(0, 1)));
            return;
        end
        if (kind >= 70 && kind < 73)
            crc = 1'b0;
        else if (kind < 75 && kind >= 73)
            id = 2'(model_id + $urandom_range(1, 3));
        else if (kind < 77 && kind >= 75)
        begin
            first = 1'b0;
            cont = 3'($urandom);
        end
        else if (kind < 79 && kind >= 77)
        begin
            padded = 1'b1;
            last = 1'b0;
        end
        else if (kind < 82 && kind >= 79)
        begin
            padded = 1'b1;
            last = 1'b1;
            useful = $urandom_range(0, 255);
        end
        else if (kind < 85 && kind >= 82)
        begin
            padded = 1'b1;
            last = 1'b1;
            dirty = 1'b1;
            if (blen >= 3)
                useful = $urandom_range(0, (blen - 2 > 255) ? 255 : blen - 2);
        end
        build_packet(first, last, padded, id, cont, blen, useful, dirty);
        if (kind < 90 && kind >= 85)
        begin
            // wrong length
            if ($urandom_range(0, 1) == 1 && pkt_bytes.size() > 1)
                void'(pkt_bytes.pop_back());
            else
                repeat ($urandom_range(1, 2)) pkt_bytes = {pkt_bytes, 8'($urandom)};
        end
        send_built(crc);
    endtask

    task automatic test_header_cases;
        build_packet(1, 1, 0, 2'd0, 3'd0, 1, 0, 0);
        pkt_bytes[1] = 8'hFF;
        send_built(1'b1);
        build_packet(1, 0, 0, 2'd0, 3'd5, 1, 0, 0);
        pkt_bytes[1] = 8'h00;
        send_built(1'b1);
        build_packet(0, 1, 0, 2'd0, 3'd6, 1, 0, 0);
        send_built(1'b1);
        // continuation with no unit open
        build_packet(0, 0, 0, 2'd0, 3'd7, 1, 0, 0);
        send_built(1'b1);
        build_packet(1, 1, 0, 2'd0, 3'd1, 1, 0, 0);
        send_built(1'b0);
        build_packet(1, 1, 0, 2'd3, 3'd1, 1, 0, 0);
        send_built(1'b1);
        build_packet(1, 0, 1, 2'd0, 3'd1, 1, 0, 0);
        send_built(1'b1);
        // padded, no useful bytes: empty unit
        build_packet(1, 1, 1, 2'd0, 3'd1, 1, 0, 0);
        send_built(1'b1);
        build_packet(1, 1, 1, 2'd0, 3'd1, 1, 1, 0);
        send_built(1'b1);
        build_packet(1, 1, 0, 2'd0, 3'd1, 1, 0, 0);
        void'(pkt_bytes.pop_back());
        send_built(1'b1);
        build_packet(1, 1, 0, 2'd0, 3'd1, 1, 0, 0);
        pkt_bytes = {pkt_bytes, 8'h5A};
        send_built(1'b1);
    endtask

    task automatic test_register_extremes;
        set_config(4, 2, 6);
        build_packet(1, 1, 1, 2'd2, 3'd0, 4, 3, 0);
        send_built(1'b1);
        build_packet(1, 1, 1, 2'd2, 3'd0, 4, 1, 1);
        send_built(1'b1);
        build_packet(1, 0, 0, 2'd2, 3'd3, 4, 0, 0);
        send_built(1'b1);
        // second packet pushes the unit past its limit
        build_packet(0, 1, 0, 2'd2, 3'd4, 4, 0, 0);
        send_built(1'b1);
        set_config(4, 2, 1);
        build_packet(1, 1, 0, 2'd2, 3'd0, 4, 0, 0);
        send_built(1'b1);
        build_packet(1, 1, 1, 2'd2, 3'd0, 4, 1, 0);
        send_built(1'b1);
        set_config(0, 0, 24'hFFFFFF);
        build_packet(1, 1, 0, 2'd0, 3'd0, 0, 0, 0);
        send_built(1'b1);
        build_packet(1, 1, 0, 2'd0, 3'd0, 0, 0, 0);
        pkt_bytes = {pkt_bytes, 8'h3C};
        send_built(1'b1);
    endtask

    task automatic test_random_traffic;
        int send_modes [4];
        int recv_modes [4];
        int body;
        int target;
        send_modes = '{0, 52, 0, 18};
        recv_modes = '{0, 0, 52, 18};
        for (int m = 0; m < 4; m++)
        begin
            for (int s = 0; s < 2; s++)
            begin
                case ($urandom_range(0, 5))
                    0:       body = 1;
                    1:       body = 2;
                    2:       body = 3;
                    3, 4:    body = $urandom_range(4, 12);
                    default: body = $urandom_range(13, 300);
                endcase
                set_config(body, $urandom_range(0, 3),
                           ($urandom_range(0, 1) == 1) ? 24'hFFFFFF
                                                       : $urandom_range(1, 3 * body + 5));
                send_idle_pct = send_modes[m];
                recv_stall_pct = recv_modes[m];
                target = bytes_sent + 120;
                while (bytes_sent < target)
                    send_random_packet();
            end
        end
    endtask

    task automatic test_backpressure;
        int target;
        set_config(3, 1, 24'hFFFFFF);
        send_idle_pct = 0;
        recv_stall_pct = 10;
        // hold the receiver off while the sender keeps offering
        @(negedge clk);
        hold_left = 300;
        @(posedge clk);
        target = bytes_sent + 120;
        while (bytes_sent < target)
            send_random_packet();
        wait_for_results();
    endtask

    task automatic test_long_packets;
        set_config(300, 1, 24'hFFFFFF);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_packet_byte(header_byte(1, 0, 2'd1, 0, 3'd2), 1'b0, 1'b1);
        for (int i = 1; i <= 300; i++)
            send_packet_byte(8'($urandom), i == 300, 1'b1);
        // padded final packet: 255 useful bytes then zero fill
        send_packet_byte(header_byte(0, 1, 2'd1, 1, 3'd3), 1'b0, 1'b0);
        send_packet_byte(8'd255, 1'b0, 1'b1);
        for (int i = 2; i <= 300; i++)
            send_packet_byte((i - 2 < 255) ? 8'($urandom) : 8'h00, i == 300, 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.packet_byte = '0;
        in_ch.end_of_packet = 1'b0;
        in_ch.crc_ok = 1'b0;
        out_ch.ready = 1'b0;
        model_body = 16'd1;
        model_id = '0;
        model_max = 24'hFFFFFF;
        unit_active_q = 1'b0;
        prev_cont = '0;
        unit_bytes = '0;
        index_q = '0;
        hdr_q = '0;
        useful_q = '0;
        fill_bad = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_header_cases();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();
        test_long_packets();

        wait_for_results();
        repeat (20) @(posedge clk);
        mismatches += expected_results.size();
        $display("covered %0d bytes in %0d packets, %0d units completed, %0d register settings",
                 bytes_sent, packets_seen, units_completed, settings_applied);
        $display("with idle and stall phases, a long receiver hold-off and a long padded unit");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
